>>> rtl/core/hub_telemetry_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// hub_telemetry_frame_parser_macros.svh
// Assertion macros shared by the frame parser RTL. Defining ASSERT_OFF
// compiles every check away.
// ----------------------------------------------------------------------------
`ifndef HUB_TELEMETRY_FRAME_PARSER_MACROS_SVH
`define HUB_TELEMETRY_FRAME_PARSER_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, disabled while the active-low reset is asserted
`define HTFP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define HTFP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define HTFP_ASSERT(label, clk, rstn, prop, msg)
`define HTFP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> rtl/core/htfp_pkg.sv
// ----------------------------------------------------------------------------
// htfp_pkg
// Types and constants for the hub telemetry frame parser.
// ----------------------------------------------------------------------------
package htfp_pkg;

    // Value table geometry
    localparam int TBL_DEPTH  = 256;
    localparam int TBL_ADDR_W = 8;
    localparam int VAL_W      = 16;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam logic REG_INVERT_MASK = 1'b0;   // register index, paddr[2]

    // Input kinds
    localparam logic KIND_SERIAL = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Line codes
    localparam logic [7:0] CH_ESCAPE = 8'h5D;
    localparam logic [7:0] CH_START  = 8'h5E;
    localparam logic [7:0] ESC_XOR   = 8'h60;

    // Table ids with a derived meaning
    localparam logic [7:0] ID_CELLS      = 8'h06;
    localparam logic [7:0] ID_ALT_WHOLE  = 8'h10;
    localparam logic [7:0] ID_ALT_FRAC   = 8'h21;
    localparam logic [7:0] ID_HEAD_WHOLE = 8'h14;
    localparam logic [7:0] ID_HEAD_FRAC  = 8'h1C;
    localparam logic [7:0] ID_VFAS       = 8'h39;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] read_id;
    } htfp_in_t;

    typedef struct packed {
        logic               frame_done;
        logic [7:0]         frame_id;
        logic [15:0]        frame_value;
        logic               frame_changed;
        logic [15:0]        raw_value;
        logic [4:0]         cell_count;
        logic [12:0]        cell_voltage;
        logic signed [22:0] altitude;
        logic [15:0]        heading;
        logic [15:0]        vfas_voltage;
    } htfp_out_t;

endpackage

>>> rtl/core/htfp_ram.sv
// ----------------------------------------------------------------------------
// htfp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module htfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

>>> rtl/core/hub_telemetry_frame_parser.sv
// ----------------------------------------------------------------------------
// hub_telemetry_frame_parser
// Hub-style serial telemetry parser with a 256-entry value table.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless the result channel stalls: a
// received serial byte (kind 0) or a raw table read (kind 1), and returns
// exactly one result per transaction. Unescaping and frame assembly happen
// at acceptance; the table compare, write and derived values follow in stage
// B from the table RAM's registered read, and the result register holds them.
// The table reads as zero after reset through per-entry valid bits, so no
// clearing pass is needed and the block is ready right out of reset.
// invert_mask sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
`include "hub_telemetry_frame_parser_macros.svh"

module hub_telemetry_frame_parser (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  htfp_pkg::htfp_in_t             s_data,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output htfp_pkg::htfp_out_t            m_data,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [htfp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import htfp_pkg::*;

    // Bytes still expected in the open frame
    localparam logic [1:0] LEFT_IDLE = 2'd0;
    localparam logic [1:0] LEFT_HI   = 2'd1;
    localparam logic [1:0] LEFT_LO   = 2'd2;
    localparam logic [1:0] LEFT_ID   = 2'd3;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [7:0] mask_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_INVERT_MASK);
    assign prdata = (paddr[2] == REG_INVERT_MASK) ? {24'b0, mask_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= 8'h00;
        end else if (cfg_wr) begin
            mask_reg <= pwdata[7:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic b_valid_reg;
    logic m_valid_reg;
    logic b_adv;
    logic s_accept;

    assign b_adv    = !m_valid_reg || m_ready;
    assign s_ready  = !b_valid_reg || b_adv;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    // ------------------------------------------------------------------
    // Stage A: unescape and frame assembly at acceptance
    // ------------------------------------------------------------------
    logic       esc_reg,  esc_next;
    logic [1:0] left_reg, left_next;
    logic [7:0] fb0_reg,  fb0_next;
    logic [7:0] fb1_reg,  fb1_next;
    logic [7:0] ch;
    logic [7:0] ch_esc;
    logic       a_done;
    logic [15:0] a_value;

    always_comb begin
        ch        = s_data.data_byte ^ mask_reg;
        ch_esc    = esc_reg ? (ch ^ ESC_XOR) : ch;
        esc_next  = esc_reg;
        left_next = left_reg;
        fb0_next  = fb0_reg;
        fb1_next  = fb1_reg;
        a_done    = 1'b0;
        a_value   = {ch_esc, fb1_reg};
        if (s_data.kind == KIND_SERIAL) begin
            if (ch == CH_ESCAPE) begin
                esc_next = 1'b1;
            end else if (ch == CH_START) begin
                left_next = LEFT_ID;
            end else if (left_reg != LEFT_IDLE) begin
                esc_next  = 1'b0;
                left_next = left_reg - 2'd1;
                case (left_reg)
                    LEFT_ID: fb0_next = ch_esc;
                    LEFT_LO: fb1_next = ch_esc;
                    LEFT_HI: a_done   = 1'b1;
                    default: a_done   = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg  <= 1'b0;
            left_reg <= LEFT_IDLE;
            fb0_reg  <= 8'h00;
            fb1_reg  <= 8'h00;
        end else if (s_accept) begin
            esc_reg  <= esc_next;
            left_reg <= left_next;
            fb0_reg  <= fb0_next;
            fb1_reg  <= fb1_next;
        end
    end

    // ------------------------------------------------------------------
    // Value table read, with forwarding of the write at the same edge
    // ------------------------------------------------------------------
    logic [TBL_ADDR_W-1:0] rd_addr;
    logic                  ram_we;
    logic [VAL_W-1:0]      ram_rdata;
    logic [TBL_DEPTH-1:0]  tbl_vld_reg;
    logic                  b_kind_reg;
    logic                  b_done_reg;
    logic [7:0]            b_id_reg;
    logic [15:0]           b_value_reg;
    logic                  b_fwd_reg;
    logic [15:0]           b_fwd_data_reg;
    logic                  b_vld_reg;

    assign rd_addr = (s_data.kind == KIND_READ) ? s_data.read_id : fb0_reg;
    assign ram_we  = b_valid_reg && b_adv && b_done_reg;

    htfp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (b_id_reg),
        .wdata (b_value_reg),
        .re    (s_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (s_ready) begin
            b_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            b_kind_reg     <= s_data.kind;
            b_done_reg     <= a_done;
            b_id_reg       <= fb0_reg;
            b_value_reg    <= a_value;
            b_fwd_reg      <= ram_we && (b_id_reg == rd_addr);
            b_fwd_data_reg <= b_value_reg;
            b_vld_reg      <= tbl_vld_reg[rd_addr];
        end
    end

    // Valid bits: an entry never written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tbl_vld_reg <= '0;
        end else if (ram_we) begin
            tbl_vld_reg[b_id_reg] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: compare, cell count, shadows of the derived entries
    // ------------------------------------------------------------------
    logic [15:0] old_value;
    logic [4:0]  cells_reg, cells_next;
    logic        b_changed;
    logic [3:0]  cell_idx;
    logic [15:0] e06_reg, e10_reg, e21_reg, e14_reg, e1c_reg, e39_reg;
    logic [15:0] e06_next, e10_next, e21_next, e14_next, e1c_next, e39_next;

    always_comb begin
        if (b_fwd_reg) begin
            old_value = b_fwd_data_reg;
        end else if (b_vld_reg) begin
            old_value = ram_rdata;
        end else begin
            old_value = 16'h0000;
        end
    end

    always_comb begin
        cell_idx   = b_value_reg[7:4];
        cells_next = cells_reg;
        b_changed  = 1'b0;
        e06_next   = e06_reg;
        e10_next   = e10_reg;
        e21_next   = e21_reg;
        e14_next   = e14_reg;
        e1c_next   = e1c_reg;
        e39_next   = e39_reg;
        if (b_done_reg) begin
            if ((b_id_reg == ID_CELLS) && ({1'b0, cell_idx} >= cells_reg)) begin
                cells_next = {1'b0, cell_idx} + 5'd1;
                b_changed  = 1'b1;
            end
            if (old_value != b_value_reg) begin
                b_changed = 1'b1;
            end
            if (b_id_reg == ID_CELLS)      e06_next = b_value_reg;
            if (b_id_reg == ID_ALT_WHOLE)  e10_next = b_value_reg;
            if (b_id_reg == ID_ALT_FRAC)   e21_next = b_value_reg;
            if (b_id_reg == ID_HEAD_WHOLE) e14_next = b_value_reg;
            if (b_id_reg == ID_HEAD_FRAC)  e1c_next = b_value_reg;
            if (b_id_reg == ID_VFAS)       e39_next = b_value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cells_reg <= 5'd0;
            e06_reg   <= 16'h0000;
            e10_reg   <= 16'h0000;
            e21_reg   <= 16'h0000;
            e14_reg   <= 16'h0000;
            e1c_reg   <= 16'h0000;
            e39_reg   <= 16'h0000;
        end else if (b_valid_reg && b_adv) begin
            cells_reg <= cells_next;
            e06_reg   <= e06_next;
            e10_reg   <= e10_next;
            e21_reg   <= e21_next;
            e14_reg   <= e14_next;
            e1c_reg   <= e1c_next;
            e39_reg   <= e39_next;
        end
    end

    // Derived values from the table after this transaction
    logic signed [22:0] alt_whole;
    logic signed [22:0] alt_scaled;
    logic signed [22:0] alt_frac;
    logic signed [22:0] altitude_c;
    logic [15:0]        heading_c;
    logic [15:0]        vfas_c;
    logic [12:0]        cell_v_c;

    always_comb begin
        alt_whole  = $signed({{7{e10_next[15]}}, e10_next});
        alt_scaled = alt_whole * 23'sd100;
        alt_frac   = $signed({7'b0, e21_next});
        altitude_c = e10_next[15] ? (alt_scaled - alt_frac) : (alt_scaled + alt_frac);
        heading_c  = 16'(e14_next * 16'd100) + e1c_next;
        vfas_c     = 16'(e39_next * 16'd100);
        cell_v_c   = {e06_next[3:0], e06_next[15:8], 1'b0};
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    htfp_out_t out_next;
    htfp_out_t out_reg;

    always_comb begin
        out_next.frame_done    = b_done_reg;
        out_next.frame_id      = b_done_reg ? b_id_reg : 8'h00;
        out_next.frame_value   = b_done_reg ? b_value_reg : 16'h0000;
        out_next.frame_changed = b_changed;
        out_next.raw_value     = (b_kind_reg == KIND_READ) ? old_value : 16'h0000;
        out_next.cell_count    = cells_next;
        out_next.cell_voltage  = cell_v_c;
        out_next.altitude      = altitude_c;
        out_next.heading       = heading_c;
        out_next.vfas_voltage  = vfas_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_adv) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv && b_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `HTFP_ASSERT(a_read_no_frame, aclk, aresetn,
        b_valid_reg && (b_kind_reg == KIND_READ) |-> !b_done_reg,
        "table read carries a completed frame")
    `HTFP_ASSERT(a_cells_range, aclk, aresetn, cells_reg <= 5'd16,
        "cell count beyond sixteen")
    `HTFP_ASSERT(a_fwd_taken, aclk, aresetn,
        ram_we && s_accept && (b_id_reg == rd_addr) |=> b_fwd_reg,
        "same-edge table write not forwarded")
    `HTFP_ASSERT(a_changed_needs_done, aclk, aresetn,
        m_valid && m_data.frame_changed |-> m_data.frame_done,
        "change flagged without a completed frame")
    `HTFP_ASSERT_ALWAYS(a_ready_when_free, aclk, !m_valid_reg |-> s_ready,
        "input stalled with an empty result register")

endmodule

>>> tb/sv/hub_telemetry_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// hub_telemetry_frame_parser_tb
// Self-checking bench for the hub telemetry frame parser. A directed table
// covers reset reads, idle bytes, escapes, frame restarts and table
// extremes. Random traffic follows, mostly well-formed frames with some
// noise, truncated frames and raw reads, under several inversion masks.
// Every result is checked field by field against a typed expectation or an in-bench
// model of the parser, with random idling on both channels but in the last pass.
// ----------------------------------------------------------------------------
module hub_telemetry_frame_parser_tb;
    import htfp_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int LONG_HOLD_CYC  = 300;
    localparam int ITEMS_PER_PASS = 150;

    // Clock, reset and DUT ports
    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    htfp_in_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    htfp_out_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Parser model state
    logic [VAL_W-1:0] tbl_model [TBL_DEPTH];
    logic [7:0]       asm_id;
    logic [7:0]       asm_lo;
    logic [1:0]       asm_left;
    logic             asm_esc;
    logic [4:0]       cells_model;
    logic [7:0]       line_mask;

    // Expected results, oldest first
    htfp_out_t        result_q[$];

    // Directed stimulus table
    typedef struct {
        htfp_in_t  item;
        bit        typed;
        htfp_out_t res;
    } dir_row_t;
    dir_row_t dir_rows[$];

    int  fail_cnt       = 0;
    int  cycle_cnt      = 0;
    int  items_sent     = 0;
    bit  tx_idle_en     = 1'b1;
    bit  rx_idle_en     = 1'b1;
    bit  long_hold_req  = 1'b0;
    int  long_hold_left = 0;
    int  rx_stall_left  = 0;

    hub_telemetry_frame_parser uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Model of one transaction; returns the result it causes
    function automatic htfp_out_t parse_predict(htfp_in_t it);
        htfp_out_t  r;
        logic [7:0] ch;
        logic [VAL_W-1:0] v;
        logic [3:0] cell_idx;
        int         whole;
        int         alt;
        logic [31:0] prod;
        r = '0;
        if (it.kind == KIND_READ) begin
            r.raw_value = tbl_model[it.read_id];
        end else begin
            ch = it.data_byte ^ line_mask;
            if (ch == CH_ESCAPE) begin
                asm_esc = 1'b1;
            end else if (ch == CH_START) begin
                asm_left = 2'd3;
            end else if (asm_left != 2'd0) begin
                if (asm_esc) ch = ch ^ ESC_XOR;
                asm_esc = 1'b0;
                if (asm_left == 2'd3) begin
                    asm_id = ch;
                end else if (asm_left == 2'd2) begin
                    asm_lo = ch;
                end else begin
                    v = {ch, asm_lo};
                    r.frame_done  = 1'b1;
                    r.frame_id    = asm_id;
                    r.frame_value = v;
                    if (asm_id == ID_CELLS) begin
                        cell_idx = v[7:4];
                        if ({1'b0, cell_idx} >= cells_model) begin
                            r.frame_changed = 1'b1;
                            cells_model     = {1'b0, cell_idx} + 5'd1;
                        end
                    end
                    if (tbl_model[asm_id] != v) begin
                        r.frame_changed   = 1'b1;
                        tbl_model[asm_id] = v;
                    end
                end
                asm_left = asm_left - 2'd1;
            end
        end
        // Derived fields from the updated table
        r.cell_count   = cells_model;
        r.cell_voltage = {tbl_model[ID_CELLS][3:0], tbl_model[ID_CELLS][15:8], 1'b0};
        whole = $signed(tbl_model[ID_ALT_WHOLE]);
        alt   = whole * 100;
        if (whole >= 0) alt = alt + int'(tbl_model[ID_ALT_FRAC]);
        else alt = alt - int'(tbl_model[ID_ALT_FRAC]);
        r.altitude = alt[22:0];
        prod = 32'(tbl_model[ID_HEAD_WHOLE]) * 32'd100 + 32'(tbl_model[ID_HEAD_FRAC]);
        r.heading = prod[15:0];
        prod = 32'(tbl_model[ID_VFAS]) * 32'd100;
        r.vfas_voltage = (tbl_model[ID_VFAS] == '0) ? 16'd0 : prod[15:0];
        return r;
    endfunction

    // Compare one result transaction with the oldest expectation
    task automatic check_result(htfp_out_t got);
        htfp_out_t want;
        if (result_q.size() == 0) begin
            $error("result transaction with no expectation waiting");
            fail_cnt++;
        end else begin
            want = result_q.pop_front();
            if (got.frame_done !== want.frame_done) begin
                $error("frame_done expected %0d got %0d", want.frame_done, got.frame_done);
                fail_cnt++;
            end
            if (got.frame_id !== want.frame_id) begin
                $error("frame_id expected %0h got %0h", want.frame_id, got.frame_id);
                fail_cnt++;
            end
            if (got.frame_value !== want.frame_value) begin
                $error("frame_value expected %0h got %0h", want.frame_value, got.frame_value);
                fail_cnt++;
            end
            if (got.frame_changed !== want.frame_changed) begin
                $error("frame_changed expected %0d got %0d",
                       want.frame_changed, got.frame_changed);
                fail_cnt++;
            end
            if (got.raw_value !== want.raw_value) begin
                $error("raw_value expected %0h got %0h", want.raw_value, got.raw_value);
                fail_cnt++;
            end
            if (got.cell_count !== want.cell_count) begin
                $error("cell_count expected %0d got %0d", want.cell_count, got.cell_count);
                fail_cnt++;
            end
            if (got.cell_voltage !== want.cell_voltage) begin
                $error("cell_voltage expected %0d got %0d",
                       want.cell_voltage, got.cell_voltage);
                fail_cnt++;
            end
            if (got.altitude !== want.altitude) begin
                $error("altitude expected %0d got %0d",
                       $signed(want.altitude), $signed(got.altitude));
                fail_cnt++;
            end
            if (got.heading !== want.heading) begin
                $error("heading expected %0d got %0d", want.heading, got.heading);
                fail_cnt++;
            end
            if (got.vfas_voltage !== want.vfas_voltage) begin
                $error("vfas_voltage expected %0d got %0d",
                       want.vfas_voltage, got.vfas_voltage);
                fail_cnt++;
            end
        end
    endtask

    // Result side: check, then decide m_ready for the next cycle
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_result(m_data);
            if (long_hold_req) begin
                long_hold_left = LONG_HOLD_CYC;
                long_hold_req  = 1'b0;
            end
            if (long_hold_left > 0) begin
                long_hold_left--;
                m_ready <= 1'b0;
            end else if (rx_idle_en && rx_stall_left > 0) begin
                rx_stall_left--;
                m_ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
                rx_stall_left = $urandom_range(1, 19) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic htfp_in_t ser(logic [7:0] b);
        htfp_in_t it;
        it.kind      = KIND_SERIAL;
        it.data_byte = b;
        it.read_id   = 8'($urandom);
        return it;
    endfunction

    function automatic htfp_in_t rd(logic [7:0] id);
        htfp_in_t it;
        it.kind      = KIND_READ;
        it.data_byte = 8'($urandom);
        it.read_id   = id;
        return it;
    endfunction

    // Offer one transaction and hold it until accepted; called at a clock edge
    task automatic send_item(htfp_in_t it, bit typed, htfp_out_t typed_res);
        htfp_out_t r;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        r = parse_predict(it);
        result_q.push_back(typed ? typed_res : r);
        items_sent++;
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic send_line(logic [7:0] ch);
        send_item(ser(ch ^ line_mask), 1'b0, '0);
    endtask

    // Start byte plus the first n frame bytes, escaping some of them
    task automatic send_frame(logic [7:0] id, logic [15:0] val, int n);
        logic [7:0] fb [3];
        logic [7:0] esc_b;
        fb[0] = id;
        fb[1] = val[7:0];
        fb[2] = val[15:8];
        send_line(CH_START);
        for (int k = 0; k < n; k++) begin
            esc_b = fb[k] ^ ESC_XOR;
            if ((fb[k] == CH_ESCAPE || fb[k] == CH_START || $urandom_range(0, 7) == 0)
                && esc_b != CH_ESCAPE && esc_b != CH_START) begin
                send_line(CH_ESCAPE);
                send_line(esc_b);
            end else begin
                send_line(fb[k]);
            end
        end
    endtask

    // Stop offering and wait for every expected result
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (result_q.size() != 0) @(posedge aclk);
    endtask

    // APB write, then read back; the block must be idle
    task automatic cfg_write(logic [7:0] mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(REG_INVERT_MASK));
        pwdata  <= {24'h0, mask};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        line_mask = mask;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[7:0] !== mask) begin
            $error("invert_mask readback expected %0h got %0h", mask, prdata[7:0]);
            fail_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_id();
        case ($urandom_range(0, 11))
            0: return ID_CELLS;
            1: return ID_ALT_WHOLE;
            2: return ID_ALT_FRAC;
            3: return ID_HEAD_WHOLE;
            4: return ID_HEAD_FRAC;
            5: return ID_VFAS;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One random unit: mostly whole frames, plus reads, noise and cut frames
    task automatic send_random_unit();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12) begin
            send_frame(pick_id(), pick_value(), 3);
        end else if (sel < 15) begin
            send_item(rd(($urandom_range(0, 1) == 0) ? pick_id() : 8'($urandom)), 1'b0, '0);
        end else if (sel < 18) begin
            send_item(ser(8'($urandom)), 1'b0, '0);
        end else begin
            send_frame(pick_id(), pick_value(), $urandom_range(0, 2));
        end
    endtask

    // Main sequence
    initial begin
        htfp_out_t r;
        logic [7:0] pass_mask [5];
        int pass_start;
        bit hold_done;

        for (int i = 0; i < TBL_DEPTH; i++) tbl_model[i] = '0;
        asm_id      = '0;
        asm_lo      = '0;
        asm_left    = '0;
        asm_esc     = 1'b0;
        cells_model = '0;
        line_mask   = '0;
        hold_done   = 1'b0;

        // Directed table; typed results only where obvious
        dir_rows.push_back('{rd(8'h00), 1'b1, '0});
        dir_rows.push_back('{rd(8'hFF), 1'b1, '0});
        dir_rows.push_back('{ser(8'h00), 1'b1, '0});
        dir_rows.push_back('{ser(8'hFF), 1'b1, '0});
        dir_rows.push_back('{ser(CH_ESCAPE), 1'b1, '0});      // escape while idle
        dir_rows.push_back('{ser(CH_ESCAPE), 1'b1, '0});      // repeated escape
        dir_rows.push_back('{ser(CH_START), 1'b1, '0});       // escape kept over start
        dir_rows.push_back('{ser(ID_ALT_WHOLE ^ ESC_XOR), 1'b1, '0});
        dir_rows.push_back('{ser(8'h00), 1'b1, '0});
        r = '0;
        r.frame_done    = 1'b1;
        r.frame_id      = ID_ALT_WHOLE;
        r.frame_value   = 16'h8000;
        r.frame_changed = 1'b1;
        r.altitude      = -23'sd3276800;
        dir_rows.push_back('{ser(8'h80), 1'b1, r});
        dir_rows.push_back('{ser(CH_START), 1'b0, '0});
        dir_rows.push_back('{ser(ID_ALT_FRAC), 1'b0, '0});
        dir_rows.push_back('{ser(8'hFF), 1'b0, '0});
        r = '0;
        r.frame_done    = 1'b1;
        r.frame_id      = ID_ALT_FRAC;
        r.frame_value   = 16'hFFFF;
        r.frame_changed = 1'b1;
        r.altitude      = -23'sd3342335;
        dir_rows.push_back('{ser(8'hFF), 1'b1, r});
        // Top cell index, then a start byte restarting an open frame
        dir_rows.push_back('{ser(CH_START), 1'b0, '0});
        dir_rows.push_back('{ser(ID_CELLS), 1'b0, '0});
        dir_rows.push_back('{ser(8'hF5), 1'b0, '0});
        dir_rows.push_back('{ser(8'hFF), 1'b0, '0});
        dir_rows.push_back('{ser(CH_START), 1'b0, '0});
        dir_rows.push_back('{ser(ID_HEAD_WHOLE), 1'b0, '0});
        dir_rows.push_back('{ser(CH_START), 1'b0, '0});
        dir_rows.push_back('{ser(ID_HEAD_FRAC), 1'b0, '0});
        dir_rows.push_back('{ser(CH_ESCAPE), 1'b0, '0});
        dir_rows.push_back('{ser(8'h7D), 1'b0, '0});
        dir_rows.push_back('{ser(8'h02), 1'b0, '0});
        dir_rows.push_back('{rd(ID_CELLS), 1'b0, '0});
        dir_rows.push_back('{rd(ID_VFAS), 1'b0, '0});

        // Reset
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
        drain();

        // Random passes under different masks; the last one without idling
        pass_mask[0] = 8'hFF;
        pass_mask[1] = 8'($urandom);
        pass_mask[2] = 8'h00;
        pass_mask[3] = 8'($urandom);
        pass_mask[4] = 8'hFF;
        for (int p = 0; p < 5; p++) begin
            cfg_write(pass_mask[p]);
            if (p == 4) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            pass_start = items_sent;
            while (items_sent - pass_start < ITEMS_PER_PASS) begin
                // Receiver holds off while the sender keeps going
                if (p == 2 && !hold_done && items_sent - pass_start >= 20) begin
                    tx_idle_en    = 1'b0;
                    long_hold_req = 1'b1;
                    hold_done     = 1'b1;
                end
                if (p == 2 && items_sent - pass_start > 60) tx_idle_en = 1'b1;
                // Sender pauses until everything has come back
                if (p == 1 && items_sent - pass_start > 70 && items_sent - pass_start < 76)
                    drain();
                send_random_unit();
            end
            drain();
        end

        repeat (8) @(posedge aclk);
        if (fail_cnt == 0 && result_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/htfp_pkg.sv
rtl/core/htfp_ram.sv
rtl/core/hub_telemetry_frame_parser.sv
tb/sv/hub_telemetry_frame_parser_tb.sv
